@@ hdl/opc_pkg.sv @@
// Package: shared types and constants for the obstacle penetration cost block
package opc_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned CostW  = 48;
  localparam int unsigned CntW   = 7;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned SqW    = 64;
  localparam int unsigned RootW  = 32;
  localparam int unsigned SqrtSteps = 32;
  localparam logic [CostW-1:0] SumMax = {CostW{1'b1}};

  localparam logic [1:0] RegWeight = 2'd0;
  localparam logic [1:0] RegSafety = 2'd1;
  localparam logic [1:0] RegCount  = 2'd2;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModePoint = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // one beat traveling down the cell row
  typedef struct packed {
    logic              vld;
    logic [SqW-1:0]    rem;
    logic [RootW-1:0]  root;
    logic              far;
  } sq_beat_t;

endpackage

@@ hdl/opc_if.sv @@
// Interfaces: valid/ready channels for input and result beats
interface opc_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [opc_pkg::SlotW-1:0]       slot;
  logic signed [opc_pkg::CoordW-1:0] pos_x;
  logic signed [opc_pkg::CoordW-1:0] pos_y;
  logic                            last_point;
  modport source (output valid, mode, slot, pos_x, pos_y, last_point, input ready);
  modport sink   (input valid, mode, slot, pos_x, pos_y, last_point, output ready);
endinterface

interface opc_out_if;
  logic                       valid;
  logic                       ready;
  logic [opc_pkg::CostW-1:0]  trajectory_cost;
  logic                       cost_saturated;
  modport source (output valid, trajectory_cost, cost_saturated, input ready);
  modport sink   (input valid, trajectory_cost, cost_saturated, output ready);
endinterface

@@ hdl/obstacle_penetration_cost.sv @@
// Top level: obstacle table, sequencer, square-root cell row and accumulator
//
//  channel | dir | handshake     | payload
//  in_     | in  | valid/ready   | mode, slot, pos_x, pos_y, last_point
//  out_    | out | valid/ready   | trajectory_cost, cost_saturated
//  cfg_    | in  | write enable  | index, 32-bit data
//
// A point issues one obstacle per cycle from the table memory into a row of
// 32 root cells, then three product stages; the next input beat waits until
// the row drains, and a final point also loads the output register.
// An obstacle write does not stall input. Reset is synchronous and leaves no
// clearing pass. Input stalls while a point runs; a final cost waits in the
// output register until taken, and a later final point waits behind it.
module obstacle_penetration_cost #(
  parameter int unsigned MAX_OBSTACLES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  opc_in_if.sink                     in_ch,
  opc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [opc_pkg::CoordW-1:0] cfg_data
);

  localparam int unsigned AddrW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_OBSTACLES + 1);
  localparam int unsigned Drain = opc_pkg::SqrtSteps + 5;
  localparam int unsigned DrW   = $clog2(Drain + 1);

  logic [opc_pkg::CoordW-1:0] weight_r, safety_r;
  logic [opc_pkg::CntW-1:0]   count_r;
  logic [opc_pkg::CoordW-1:0] mem_x [MAX_OBSTACLES];
  logic [opc_pkg::CoordW-1:0] mem_y [MAX_OBSTACLES];
  logic [opc_pkg::CoordW-1:0] rd_x_r, rd_y_r;
  logic                       rd_v_r;

  opc_pkg::state_t state_r, state_nxt;
  logic [CntW-1:0] idx_r, idx_nxt, n_eff;
  logic [DrW-1:0]  dr_r, dr_nxt;
  logic signed [opc_pkg::CoordW-1:0] px_r, py_r;
  logic last_r, last_nxt;
  logic [opc_pkg::CoordW-1:0] px_nxt, py_nxt;
  logic issue, clear, out_v_r, out_v_nxt, sat_r;
  logic [opc_pkg::CostW-1:0] cost_r, sum;
  logic ovf, load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= 32'd65536;
      safety_r <= 32'd32768;
      count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        opc_pkg::RegWeight: weight_r <= cfg_data;
        opc_pkg::RegSafety: safety_r <= cfg_data;
        opc_pkg::RegCount:  count_r  <= cfg_data[opc_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = ({25'd0, count_r} > 32'(MAX_OBSTACLES)) ? CntW'(MAX_OBSTACLES)
               : CntW'(count_r);
  assign in_ch.ready = (state_r == opc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && in_ch.mode == opc_pkg::ModeWrite &&
        32'(in_ch.slot) < 32'(MAX_OBSTACLES)) begin
      mem_x[AddrW'(in_ch.slot)] <= in_ch.pos_x;
      mem_y[AddrW'(in_ch.slot)] <= in_ch.pos_y;
    end
    rd_x_r <= mem_x[idx_r[AddrW-1:0]];
    rd_y_r <= mem_y[idx_r[AddrW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    dr_nxt    = dr_r;
    last_nxt  = last_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    issue     = 1'b0;
    clear     = 1'b0;
    load      = 1'b0;
    out_v_nxt = out_v_r && !out_ch.ready;
    unique case (state_r)
      opc_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.mode == opc_pkg::ModePoint) begin
          px_nxt = in_ch.pos_x;
          py_nxt = in_ch.pos_y;
          last_nxt = in_ch.last_point;
          idx_nxt = '0;
          state_nxt = opc_pkg::ST_RUN;
        end
      end
      opc_pkg::ST_RUN: begin
        if (idx_r < n_eff) begin
          issue = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          dr_nxt = '0;
          state_nxt = opc_pkg::ST_DRAIN;
        end
      end
      opc_pkg::ST_DRAIN: begin
        dr_nxt = dr_r + 1'b1;
        if (dr_r == DrW'(Drain)) begin
          state_nxt = last_r ? opc_pkg::ST_OUT : opc_pkg::ST_IDLE;
        end
      end
      opc_pkg::ST_OUT: begin
        if (!out_v_r || out_ch.ready) begin
          load = 1'b1;
          clear = 1'b1;
          out_v_nxt = 1'b1;
          state_nxt = opc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = opc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= opc_pkg::ST_IDLE;
      idx_r   <= '0;
      dr_r    <= '0;
      out_v_r <= 1'b0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      dr_r    <= dr_nxt;
      out_v_r <= out_v_nxt;
      rd_v_r  <= issue;
    end
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    last_r <= last_nxt;
    if (load) begin
      cost_r <= sum;
      sat_r  <= ovf;
    end
  end

  // difference and squares ahead of the cell row
  logic [32:0] dx, dy;
  logic [65:0] dx2_r, dy2_r;
  logic        sqv_r;
  logic [66:0] sq;
  opc_pkg::sq_beat_t chain [opc_pkg::SqrtSteps+1];

  always_comb begin
    dx = (px_r >= $signed(rd_x_r)) ? 33'({px_r[31], px_r} - {rd_x_r[31], rd_x_r})
                                  : 33'({rd_x_r[31], rd_x_r} - {px_r[31], px_r});
    dy = (py_r >= $signed(rd_y_r)) ? 33'({py_r[31], py_r} - {rd_y_r[31], rd_y_r})
                                  : 33'({rd_y_r[31], rd_y_r} - {py_r[31], py_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sqv_r <= 1'b0;
    else        sqv_r <= rd_v_r;
    dx2_r <= {33'd0, dx} * {33'd0, dx};
    dy2_r <= {33'd0, dy} * {33'd0, dy};
  end

  assign sq = {1'b0, dx2_r} + {1'b0, dy2_r};
  assign chain[0].vld  = sqv_r;
  assign chain[0].rem  = sq[63:0];
  assign chain[0].root = '0;
  assign chain[0].far  = |sq[66:64];

  for (genvar g = 0; g < opc_pkg::SqrtSteps; g++) begin : g_cell
    opc_sqrt_cell #(.Step(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .beat_i(chain[g]), .beat_o(chain[g+1])
    );
  end

  opc_term u_term (
    .clk(clk), .rst_n(rst_n), .beat_i(chain[opc_pkg::SqrtSteps]),
    .weight(weight_r), .safety(safety_r), .clear(clear),
    .sum(sum), .ovf(ovf)
  );

  assign out_ch.valid           = out_v_r;
  assign out_ch.trajectory_cost = cost_r;
  assign out_ch.cost_saturated  = sat_r;

endmodule

@@ hdl/opc_sqrt_cell.sv @@
// Cell: one digit-recurrence step of the integer square root
module opc_sqrt_cell #(
  parameter int unsigned Step = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  opc_pkg::sq_beat_t beat_i,
  output opc_pkg::sq_beat_t beat_o
);

  localparam int unsigned BitPos = 2 * (opc_pkg::SqrtSteps - 1 - Step);
  localparam int unsigned RootSh = opc_pkg::SqrtSteps - Step;

  opc_pkg::sq_beat_t beat_r, beat_nxt;
  logic [opc_pkg::SqW:0] trial;
  logic [opc_pkg::SqW:0] root_shift;

  always_comb begin
    root_shift = {{(opc_pkg::SqW - opc_pkg::RootW + 1){1'b0}}, beat_i.root} << RootSh;
    trial = root_shift + ({{opc_pkg::SqW{1'b0}}, 1'b1} << BitPos);
    beat_nxt = beat_i;
    beat_nxt.root = beat_i.root;
    if ({1'b0, beat_i.rem} >= trial) begin
      beat_nxt.rem = beat_i.rem - trial[opc_pkg::SqW-1:0];
      beat_nxt.root[opc_pkg::SqrtSteps-1-Step] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else begin
      beat_r.vld <= beat_nxt.vld;
    end
    beat_r.rem  <= beat_nxt.rem;
    beat_r.root <= beat_nxt.root;
    beat_r.far  <= beat_nxt.far;
  end

  assign beat_o = beat_r;

endmodule

@@ hdl/opc_term.sv @@
// Penalty term and saturating accumulator behind the root cells
module opc_term (
  input  logic                       clk,
  input  logic                       rst_n,
  input  opc_pkg::sq_beat_t          beat_i,
  input  logic [opc_pkg::CoordW-1:0] weight,
  input  logic [opc_pkg::CoordW-1:0] safety,
  input  logic                       clear,
  output logic [opc_pkg::CostW-1:0]  sum,
  output logic                       ovf
);

  logic        v1_r, v2_r, v3_r;
  logic [31:0] pen_r;
  logic [63:0] p2_r;
  logic [63:0] hi_r, lo_r;
  logic [opc_pkg::CostW-1:0] sum_r, sum_nxt;
  logic        ovf_r, ovf_nxt;
  logic [63:0] s;
  logic [opc_pkg::CostW-1:0] t;
  logic        pos;

  assign pos = !beat_i.far && (safety > beat_i.root);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= beat_i.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    pen_r <= pos ? safety - beat_i.root : '0;
    p2_r  <= {32'd0, pen_r} * {32'd0, pen_r};
    hi_r  <= {32'd0, p2_r[63:32]} * {32'd0, weight};
    lo_r  <= {32'd0, p2_r[31:0]} * {32'd0, weight};
  end

  always_comb begin
    s = hi_r + {32'd0, lo_r[63:32]};
    t = s[63:16];
    sum_nxt = sum_r;
    ovf_nxt = ovf_r;
    if (v3_r) begin
      if (t > opc_pkg::SumMax - sum_r) begin
        sum_nxt = opc_pkg::SumMax;
        ovf_nxt = 1'b1;
      end else begin
        sum_nxt = sum_r + t;
      end
    end
    if (clear) begin
      sum_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign sum  = sum_r;
  assign ovf  = ovf_r;

endmodule

@@ hdl/opc_checker.sv @@
// Checker: port-level assertions for the obstacle penetration cost block
module opc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_mode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [opc_pkg::CostW-1:0] out_cost
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cost))
    else $error("result dropped or changed while stalled");

  a_point_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode |=> !in_ready)
    else $error("input taken during point processing");

  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_mode |=> in_ready)
    else $error("obstacle write stalled input");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind obstacle_penetration_cost opc_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_mode(in_ch.mode),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_cost(out_ch.trajectory_cost)
);
